// File: hw/rtl/rmth_pkg.sv
// Package for the running median block.
// Holds the sequencer state type and the operation struct shared by the chains.
// No dependencies.
package rmth_pkg;

    // Sequencer states of the top level.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INSERT,
        ST_BALANCE,
        ST_FINISH
    } t_state;

    // Operation applied to every cell of one chain in a cycle.
    typedef struct packed {
        logic insert;
        logic pop;
    } t_chain_op;

endpackage

// File: hw/rtl/running_median_two_heaps.sv
// Top level of the running median: sequencer, sizes and the two sorted chains.
// Depends on rmth_pkg and rmth_chain.
//
//   Channel  Handshake                   Payload
//   input    i_in_valid / o_in_ready     i_sample, i_restart
//   output   o_out_valid / i_out_ready   o_median_doubled, o_item_count, o_dropped
//
// A sample goes through accept, insert into one chain, rebalance and result;
// a dropped one skips to result. The sequencer steps one chain operation per cycle.
// Reset clears the sizes, the held median and the control state; chain contents
// are not cleared, since only cells below the size count are ever used.
// A result that is not taken holds the sequencer in its last step; a new
// transaction is accepted while the previous result still waits.
module running_median_two_heaps #(
    parameter int CAPACITY    = 256,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic                          i_restart,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [SAMPLE_BITS:0]   o_median_doubled,
    output logic [$clog2(CAPACITY+1)-1:0] o_item_count,
    output logic                          o_dropped
);

    localparam int HALF_DEPTH = CAPACITY / 2 + 2;
    localparam int HALF_BITS  = $clog2(HALF_DEPTH + 1);
    localparam int COUNT_BITS = $clog2(CAPACITY + 1);
    localparam int MED_BITS   = SAMPLE_BITS + 1;

    rmth_pkg::t_state r_state, n_state;

    logic signed [SAMPLE_BITS-1:0] r_sample, n_sample;
    logic        [HALF_BITS-1:0]   r_lsz, n_lsz;
    logic        [HALF_BITS-1:0]   r_usz, n_usz;
    logic signed [MED_BITS-1:0]    r_med, n_med;
    logic                          r_dropped, n_dropped;
    logic                          r_out_valid, n_out_valid;
    logic signed [MED_BITS-1:0]    r_out_med, n_out_med;
    logic        [COUNT_BITS-1:0]  r_out_count, n_out_count;
    logic                          r_out_dropped, n_out_dropped;

    rmth_pkg::t_chain_op           w_lower_op, w_upper_op;
    logic signed [SAMPLE_BITS-1:0] w_lower_in, w_upper_in;
    logic signed [SAMPLE_BITS-1:0] w_lower_top, w_upper_top;
    logic signed [SAMPLE_BITS-1:0] w_upper_val;
    logic signed [MED_BITS-1:0]    w_twice;
    logic signed [MED_BITS-1:0]    w_new_med;
    logic        [COUNT_BITS-1:0]  w_total;
    logic        [COUNT_BITS-1:0]  w_eff_total;
    logic        [HALF_BITS:0]     w_lsz_ext, w_usz_ext;
    logic                          w_to_lower;
    logic                          w_out_free;

    // The upper chain stores inverted samples, so its largest entry is the smallest sample.
    assign w_upper_val = ~w_upper_top;
    assign w_twice     = $signed({r_sample, 1'b0});
    assign w_total     = COUNT_BITS'(r_lsz) + COUNT_BITS'(r_usz);
    assign w_eff_total = i_restart ? '0 : w_total;
    assign w_lsz_ext   = {1'b0, r_lsz};
    assign w_usz_ext   = {1'b0, r_usz};
    assign w_to_lower  = (w_twice < r_med) || ((w_twice == r_med) && (r_lsz <= r_usz));
    assign w_out_free  = !r_out_valid || i_out_ready;

    // Median from the two chain tops, doubled.
    always_comb begin
        if (r_lsz > r_usz) begin
            w_new_med = $signed({w_lower_top, 1'b0});
        end else if (r_usz > r_lsz) begin
            w_new_med = $signed({w_upper_val, 1'b0});
        end else begin
            w_new_med = $signed({w_lower_top[SAMPLE_BITS-1], w_lower_top})
                      + $signed({w_upper_val[SAMPLE_BITS-1], w_upper_val});
        end
    end

    // Sequencer: next state, chain operations and result register loads.
    always_comb begin
        n_state       = r_state;
        n_sample      = r_sample;
        n_lsz         = r_lsz;
        n_usz         = r_usz;
        n_med         = r_med;
        n_dropped     = r_dropped;
        n_out_valid   = r_out_valid && !i_out_ready;
        n_out_med     = r_out_med;
        n_out_count   = r_out_count;
        n_out_dropped = r_out_dropped;
        w_lower_op    = '0;
        w_upper_op    = '0;
        w_lower_in    = r_sample;
        w_upper_in    = ~r_sample;
        o_in_ready    = 1'b0;

        case (r_state)
            rmth_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_sample = i_sample;
                    if (i_restart) begin
                        n_lsz = '0;
                        n_usz = '0;
                        n_med = '0;
                    end
                    if (w_eff_total >= COUNT_BITS'(CAPACITY)) begin
                        n_dropped = 1'b1;
                    end else begin
                        n_dropped = 1'b0;
                    end
                    n_state = (w_eff_total >= COUNT_BITS'(CAPACITY)) ?
                              rmth_pkg::ST_FINISH : rmth_pkg::ST_INSERT;
                end
            end

            rmth_pkg::ST_INSERT: begin
                if (w_to_lower) begin
                    w_lower_op.insert = 1'b1;
                    n_lsz = r_lsz + HALF_BITS'(1);
                end else begin
                    w_upper_op.insert = 1'b1;
                    n_usz = r_usz + HALF_BITS'(1);
                end
                n_state = rmth_pkg::ST_BALANCE;
            end

            rmth_pkg::ST_BALANCE: begin
                // Move the top of an oversized half across to the other.
                if (w_lsz_ext > w_usz_ext + (HALF_BITS+1)'(1)) begin
                    w_lower_op.pop    = 1'b1;
                    w_upper_op.insert = 1'b1;
                    w_upper_in        = ~w_lower_top;
                    n_lsz = r_lsz - HALF_BITS'(1);
                    n_usz = r_usz + HALF_BITS'(1);
                end else if (w_usz_ext > w_lsz_ext + (HALF_BITS+1)'(1)) begin
                    w_upper_op.pop    = 1'b1;
                    w_lower_op.insert = 1'b1;
                    w_lower_in        = w_upper_val;
                    n_usz = r_usz - HALF_BITS'(1);
                    n_lsz = r_lsz + HALF_BITS'(1);
                end
                n_state = rmth_pkg::ST_FINISH;
            end

            rmth_pkg::ST_FINISH: begin
                if (w_out_free) begin
                    if (!r_dropped) begin
                        n_med     = w_new_med;
                        n_out_med = w_new_med;
                    end else begin
                        n_out_med = r_med;
                    end
                    n_out_count   = w_total;
                    n_out_dropped = r_dropped;
                    n_out_valid   = 1'b1;
                    n_state       = rmth_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = rmth_pkg::ST_IDLE;
            end
        endcase
    end

    // Control and size registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rmth_pkg::ST_IDLE;
            r_lsz       <= '0;
            r_usz       <= '0;
            r_med       <= '0;
            r_dropped   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_lsz       <= n_lsz;
            r_usz       <= n_usz;
            r_med       <= n_med;
            r_dropped   <= n_dropped;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_sample      <= n_sample;
        r_out_med     <= n_out_med;
        r_out_count   <= n_out_count;
        r_out_dropped <= n_out_dropped;
    end

    // Lower half: samples at or below the median, largest at the head.
    rmth_chain #(
        .DEPTH      (HALF_DEPTH),
        .SAMPLE_BITS(SAMPLE_BITS),
        .SIZE_BITS  (HALF_BITS)
    ) u_lower (
        .i_clk   (i_clk),
        .i_op    (w_lower_op),
        .i_sample(w_lower_in),
        .i_size  (r_lsz),
        .o_top   (w_lower_top)
    );

    // Upper half: inverted samples, so the smallest sample sits at the head.
    rmth_chain #(
        .DEPTH      (HALF_DEPTH),
        .SAMPLE_BITS(SAMPLE_BITS),
        .SIZE_BITS  (HALF_BITS)
    ) u_upper (
        .i_clk   (i_clk),
        .i_op    (w_upper_op),
        .i_sample(w_upper_in),
        .i_size  (r_usz),
        .o_top   (w_upper_top)
    );

    assign o_out_valid      = r_out_valid;
    assign o_median_doubled = r_out_med;
    assign o_item_count     = r_out_count;
    assign o_dropped        = r_out_dropped;

endmodule

// File: hw/rtl/rmth_cell.sv
// One cell of a sorted chain: holds a single value of a half.
// Depends on rmth_pkg (t_chain_op).
module rmth_cell #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          i_clk,
    input  rmth_pkg::t_chain_op           i_op,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic                          i_occupied,
    input  logic                          i_prev_keep,
    input  logic signed [SAMPLE_BITS-1:0] i_prev_value,
    input  logic signed [SAMPLE_BITS-1:0] i_next_value,
    output logic signed [SAMPLE_BITS-1:0] o_value,
    output logic                          o_keep
);

    logic signed [SAMPLE_BITS-1:0] r_value;
    logic signed [SAMPLE_BITS-1:0] n_value;

    // The cell keeps its place when it is filled and ranks at or above the new value.
    assign o_keep  = i_occupied && (r_value >= i_sample);
    assign o_value = r_value;

    // Pop shifts toward the top; insert opens a gap at the first cell that yields.
    always_comb begin
        n_value = r_value;
        if (i_op.pop) begin
            n_value = i_next_value;
        end else if (i_op.insert && !o_keep) begin
            if (i_prev_keep) begin
                n_value = i_sample;
            end else begin
                n_value = i_prev_value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

// File: hw/rtl/rmth_chain.sv
// A chain of cells kept in descending order, largest value in cell zero.
// Depends on rmth_pkg and rmth_cell.
module rmth_chain #(
    parameter int DEPTH       = 130,
    parameter int SAMPLE_BITS = 16,
    parameter int SIZE_BITS   = $clog2(DEPTH + 1)
) (
    input  logic                          i_clk,
    input  rmth_pkg::t_chain_op           i_op,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic        [SIZE_BITS-1:0]   i_size,
    output logic signed [SAMPLE_BITS-1:0] o_top
);

    logic signed [SAMPLE_BITS-1:0] w_value [DEPTH];
    logic                          w_keep  [DEPTH];

    // Each cell talks only to its two neighbors; occupancy comes from the size count.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic                          w_occupied;
        logic                          w_prev_keep;
        logic signed [SAMPLE_BITS-1:0] w_prev_value;
        logic signed [SAMPLE_BITS-1:0] w_next_value;

        assign w_occupied = (SIZE_BITS'(g) < i_size);

        if (g == 0) begin : g_head
            assign w_prev_keep  = 1'b1;
            assign w_prev_value = i_sample;
        end else begin : g_body
            assign w_prev_keep  = w_keep[g-1];
            assign w_prev_value = w_value[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign w_next_value = w_value[g];
        end else begin : g_link
            assign w_next_value = w_value[g+1];
        end

        rmth_cell #(
            .SAMPLE_BITS(SAMPLE_BITS)
        ) u_cell (
            .i_clk       (i_clk),
            .i_op        (i_op),
            .i_sample    (i_sample),
            .i_occupied  (w_occupied),
            .i_prev_keep (w_prev_keep),
            .i_prev_value(w_prev_value),
            .i_next_value(w_next_value),
            .o_value     (w_value[g]),
            .o_keep      (w_keep[g])
        );
    end

    assign o_top = w_value[0];

endmodule
